### hw/rtl/scc_pkg.sv
// Shared types, constants and helper functions for the SCC counter.
`default_nettype none

package scc_pkg;

  localparam int unsigned ROW_W  = 64;  // adjacency row width
  localparam int unsigned NODE_W = 6;   // node number width
  localparam int unsigned CNT_W  = 7;   // counts up to 64

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_F_ROOT,
    ST_F_EXP,
    ST_F_POP,
    ST_B_NEXT,
    ST_B_ROOT,
    ST_B_SWEEP,
    ST_DONE
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;
    logic f_root;
    logic f_push;
    logic f_finish;
    logic f_pop;
    logic b_start;
    logic b_fetch;
    logic b_root;
    logic b_step;
    logic clear;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic root_avail;
    logic next_any;
    logic sp_zero;
    logic bi_zero;
    logic root_visited;
    logic sweep_last;
    logic sweep_more;
  } sts_t;

  // find-first-set, lowest index wins
  function automatic logic [NODE_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = NODE_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [ROW_W-1:0] node_bit(input logic [NODE_W-1:0] n);
    return {{(ROW_W-1){1'b0}}, 1'b1} << n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/scc_dp.sv
// SCC counter datapath: row, stack and finish-order memories, masks and counters.
`default_nettype none

module scc_dp import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [ROW_W-1:0] row_i,
  output sts_t                  sts_o,
  output logic [CNT_W-1:0]      tally_o
);

  localparam int unsigned IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [ROW_W-1:0] adj_mem [MAX_NODES];
  logic [IDX_W-1:0] stk_mem [MAX_NODES];
  logic [IDX_W-1:0] fin_mem [MAX_NODES];

  logic [ROW_W-1:0] adj_rd_q;
  logic [IDX_W-1:0] stk_rd_q, fin_rd_q;
  logic [IDX_W-1:0] adj_raddr;

  logic [CNT_W-1:0] row_cnt_q, row_cnt_d;
  logic [CNT_W-1:0] sp_q, sp_d;
  logic [CNT_W-1:0] done_q, done_d;
  logic [CNT_W-1:0] bi_q, bi_d;
  logic [CNT_W-1:0] tally_q, tally_d;
  logic [IDX_W-1:0] top_q, top_d;
  logic [IDX_W-1:0] su_q, su_d;
  logic [ROW_W-1:0] visited_q, visited_d;
  logic [ROW_W-1:0] comp_q, comp_d;
  logic             changed_q, changed_d;

  logic [ROW_W-1:0]  node_mask, free_set, next_set;
  logic [NODE_W-1:0] root_full, next_full;
  logic [IDX_W-1:0]  root_id, next_id;
  logic [CNT_W-1:0]  sp_dec, bi_dec;
  logic              room, hit, last_row;

  // rows at or above the loaded count are masked off
  assign node_mask = ~({ROW_W{1'b1}} << row_cnt_q);
  assign free_set  = node_mask & ~visited_q;
  assign next_set  = adj_rd_q & free_set;
  assign root_full = lowest_set(free_set);
  assign next_full = lowest_set(next_set);
  assign root_id   = root_full[IDX_W-1:0];
  assign next_id   = next_full[IDX_W-1:0];
  assign sp_dec    = sp_q - CNT_W'(1);
  assign bi_dec    = bi_q - CNT_W'(1);
  assign room      = row_cnt_q < CNT_W'(MAX_NODES);
  assign hit       = !visited_q[su_q] && (|(adj_rd_q & comp_q));
  assign last_row  = (CNT_W'(su_q) + CNT_W'(1)) == row_cnt_q;

  always_comb begin
    adj_raddr = top_q;
    if (cmd_i.f_root) begin
      adj_raddr = root_id;
    end else if (cmd_i.f_push) begin
      adj_raddr = next_id;
    end else if (cmd_i.f_pop) begin
      adj_raddr = stk_rd_q;
    end else if (cmd_i.b_root) begin
      adj_raddr = '0;
    end else if (cmd_i.b_step) begin
      adj_raddr = last_row ? '0 : su_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      adj_mem[row_cnt_q[IDX_W-1:0]] <= row_i;
    end
    adj_rd_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.f_push) begin
      stk_mem[sp_q[IDX_W-1:0]] <= top_q;
    end
    stk_rd_q <= stk_mem[sp_dec[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.f_finish) begin
      fin_mem[done_q[IDX_W-1:0]] <= top_q;
    end
    fin_rd_q <= fin_mem[bi_dec[IDX_W-1:0]];
  end

  always_comb begin
    row_cnt_d = row_cnt_q;
    sp_d      = sp_q;
    done_d    = done_q;
    bi_d      = bi_q;
    tally_d   = tally_q;
    top_d     = top_q;
    su_d      = su_q;
    visited_d = visited_q;
    comp_d    = comp_q;
    changed_d = changed_q;

    if (cmd_i.load && room) begin
      row_cnt_d = row_cnt_q + CNT_W'(1);
    end
    if (cmd_i.f_root) begin
      visited_d = visited_q | node_bit(NODE_W'(root_id));
      top_d     = root_id;
      sp_d      = '0;
    end
    if (cmd_i.f_push) begin
      visited_d = visited_q | node_bit(NODE_W'(next_id));
      top_d     = next_id;
      sp_d      = sp_q + CNT_W'(1);
    end
    if (cmd_i.f_finish) begin
      done_d = done_q + CNT_W'(1);
      if (sp_q != '0) begin
        sp_d = sp_dec;
      end
    end
    if (cmd_i.f_pop) begin
      top_d = stk_rd_q;
    end
    if (cmd_i.b_start) begin
      visited_d = '0;
      tally_d   = '0;
      bi_d      = done_q;
    end
    if (cmd_i.b_fetch) begin
      bi_d = bi_dec;
    end
    if (cmd_i.b_root) begin
      visited_d = visited_q | node_bit(NODE_W'(fin_rd_q));
      comp_d    = node_bit(NODE_W'(fin_rd_q));
      tally_d   = tally_q + CNT_W'(1);
      su_d      = '0;
      changed_d = 1'b0;
    end
    if (cmd_i.b_step) begin
      // row su_q has an edge into the component: it joins it
      if (hit) begin
        visited_d = visited_q | node_bit(NODE_W'(su_q));
        comp_d    = comp_q | node_bit(NODE_W'(su_q));
      end
      if (last_row) begin
        su_d      = '0;
        changed_d = 1'b0;
      end else begin
        su_d      = su_q + IDX_W'(1);
        changed_d = changed_q | hit;
      end
    end
    if (cmd_i.clear) begin
      row_cnt_d = '0;
      sp_d      = '0;
      done_d    = '0;
      bi_d      = '0;
      tally_d   = '0;
      visited_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      sp_q      <= '0;
      done_q    <= '0;
      bi_q      <= '0;
      tally_q   <= '0;
      top_q     <= '0;
      su_q      <= '0;
      visited_q <= '0;
      comp_q    <= '0;
      changed_q <= 1'b0;
    end else begin
      row_cnt_q <= row_cnt_d;
      sp_q      <= sp_d;
      done_q    <= done_d;
      bi_q      <= bi_d;
      tally_q   <= tally_d;
      top_q     <= top_d;
      su_q      <= su_d;
      visited_q <= visited_d;
      comp_q    <= comp_d;
      changed_q <= changed_d;
    end
  end

  assign sts_o.root_avail   = |free_set;
  assign sts_o.next_any     = |next_set;
  assign sts_o.sp_zero      = (sp_q == '0);
  assign sts_o.bi_zero      = (bi_q == '0);
  assign sts_o.root_visited = visited_q[fin_rd_q];
  assign sts_o.sweep_last   = last_row;
  assign sts_o.sweep_more   = changed_q | hit;
  assign tally_o            = tally_q;

  // a push never takes the stack past the loaded node count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.f_push |-> ((sp_q + CNT_W'(2)) <= row_cnt_q))
    else $error("search stack overrun");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= row_cnt_q)
    else $error("more nodes finished than loaded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q <= row_cnt_q)
    else $error("component tally above node count");

endmodule

`default_nettype wire

### hw/rtl/scc_ctrl.sv
// SCC counter controller: load, forward search, reverse sweep and result hand-off.
`default_nettype none

module scc_ctrl import scc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  input  wire logic out_busy_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      in_stall_o,
  output logic      emit_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    emit_o     = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_F_ROOT;
          end
        end
      end
      ST_F_ROOT: begin
        if (sts_i.root_avail) begin
          cmd_o.f_root = 1'b1;
          state_d      = ST_F_EXP;
        end else begin
          cmd_o.b_start = 1'b1;
          state_d       = ST_B_NEXT;
        end
      end
      ST_F_EXP: begin
        if (sts_i.next_any) begin
          cmd_o.f_push = 1'b1;
        end else begin
          cmd_o.f_finish = 1'b1;
          state_d        = sts_i.sp_zero ? ST_F_ROOT : ST_F_POP;
        end
      end
      ST_F_POP: begin
        cmd_o.f_pop = 1'b1;
        state_d     = ST_F_EXP;
      end
      ST_B_NEXT: begin
        if (sts_i.bi_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.b_fetch = 1'b1;
          state_d       = ST_B_ROOT;
        end
      end
      ST_B_ROOT: begin
        if (sts_i.root_visited) begin
          state_d = ST_B_NEXT;
        end else begin
          cmd_o.b_root = 1'b1;
          state_d      = ST_B_SWEEP;
        end
      end
      ST_B_SWEEP: begin
        cmd_o.b_step = 1'b1;
        if (sts_i.sweep_last && !sts_i.sweep_more) begin
          state_d = ST_B_NEXT;
        end
      end
      ST_DONE: begin
        if (!out_busy_i) begin
          emit_o      = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/scc_counter.sv
// Top level of the strongly connected component counter (two-pass search).
// Load: one adjacency row request per cycle while the input is not stalled; the request
// marked last starts the count. The count then runs the forward search from each unvisited
// root, then reverse sweeps from the finish entries in reverse order, then the result hand-off.
// Input is stalled from the last row until the count moves into the result register.
// Reset clears control, counters, visited mask and result valid; memories and count data stay.
`default_nettype none

module scc_counter import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ROW_W-1:0] adjacency_row_i,
  input  wire logic             is_last_row_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [CNT_W-1:0]      component_count_o
);

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] tally;
  logic             emit;
  logic             out_busy;

  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] count_q;

  // result slot is held while the receiver stalls it
  assign out_busy = out_valid_q & out_stall_i;

  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (is_last_row_i),
    .out_busy_i (out_busy),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .emit_o     (emit)
  );

  scc_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .row_i   (adjacency_row_i),
    .sts_o   (sts),
    .tally_o (tally)
  );

  // output register: a new graph may load while the count waits here
  assign out_valid_d = emit | out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      count_q <= tally;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign component_count_o = count_q;

  // every loaded graph has at least one node, so at least one component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (component_count_o != '0))
    else $error("empty component count presented");

endmodule

`default_nettype wire
